FILE: sv/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Widths, register indexes and shared types of the fixed-point matrix
// multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int ELEM_W    = 16;
  localparam int MUL_W     = 2 * ELEM_W;
  localparam int PROD_W    = 35;
  localparam int POS_W     = 3;
  localparam int DIM_REG_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

FILE: sv/mm_load_if.sv
// ----------------------------------------------------------------------------
// Load channel
// Valid/ready channel carrying one tagged matrix element per word.
// ----------------------------------------------------------------------------
interface mm_load_if import mm_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             which_matrix;
  logic [POS_W-1:0] row_index;
  logic [POS_W-1:0] col_index;
  elem_t            element;
  logic             last_load;

  modport source (
    output valid, which_matrix, row_index, col_index, element, last_load,
    input  ready
  );

  modport sink (
    input  valid, which_matrix, row_index, col_index, element, last_load,
    output ready
  );

endinterface

FILE: sv/mm_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one product element per word.
// ----------------------------------------------------------------------------
interface mm_result_if import mm_pkg::*; ();

  logic             valid;
  logic             ready;
  prod_t            product;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             size_error;
  logic             last_result;

  modport source (
    output valid, product, out_row, out_col, size_error, last_result,
    input  ready
  );

  modport sink (
    input  valid, product, out_row, out_col, size_error, last_result,
    output ready
  );

endinterface

FILE: sv/mm_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered Q8.8 multiplier followed by a Q19.16 accumulator; flags the
// cycle on which the sum of one dot product is complete.
// ----------------------------------------------------------------------------
module mm_mac import mm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  elem_t     a_i,
  input  elem_t     b_i,
  output prod_t     acc_o,
  output logic      done_o
);

  logic signed [MUL_W-1:0] mul_d, mul_q;
  mac_ctrl_t               ctrl_q;
  prod_t                   acc_d, acc_q;
  logic                    done_q;

  assign mul_d = a_i * b_i;
  assign acc_d = (ctrl_q.first ? '0 : acc_q) + PROD_W'(mul_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_i;
      done_q <= ctrl_q.valid && ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    if (ctrl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

FILE: sv/matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// Matrix multiply core
// Fixed-point general matrix multiply over two on-chip element stores.
// ----------------------------------------------------------------------------
// Elements are loaded one word per cycle, while idle, into the left or right
// store. The word flagged last_load starts the run: the block stops taking
// loads and computes each product element in row-major order with one shared
// multiply-accumulate unit, reading one entry of each store per cycle. Each
// element issues one read per inner index, passes the read, multiply and
// accumulate registers and is handed over to the output register, where
// output stalls can hold the run. A size mismatch yields its single error
// word through the error state and the output register after the last load.
// The stores are not cleared: read only entries that have been loaded.
module matrix_multiply_core import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_REG_W-1:0] cfg_data_i,
  mm_load_if.sink              load_i,
  mm_result_if.source          result_o
);

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_CMP_W = DIM_REG_W + 2;
  localparam logic [DIM_CMP_W-1:0] MAX_DIM_V = DIM_CMP_W'(MAX_DIM);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_ERR   = 3'd4;

  function automatic logic [DIM_W-1:0] eff_last(input logic [DIM_REG_W-1:0] r);
    logic [DIM_CMP_W-1:0] rx;
    rx = DIM_CMP_W'(r);
    if (r == '0) return '0;
    if (rx > MAX_DIM_V) return DIM_W'(MAX_DIM - 1);
    return DIM_W'(rx - 1'b1);
  endfunction

  logic [DIM_REG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [DIM_W-1:0]     ra_last, ca_last, rb_last, cb_last;

  logic [2:0]       state_q, state_d;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  mac_ctrl_t        rd_ctrl_q, rd_ctrl_d;

  elem_t            left_mem  [DEPTH];
  elem_t            right_mem [DEPTH];
  elem_t            a_rd_q, b_rd_q;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  logic             load_hs, in_range;

  prod_t            acc;
  logic             mac_done;

  logic             out_valid_q, out_valid_d, out_load, out_free;
  prod_t            out_prod_q, out_prod_d;
  logic [POS_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic             out_err_q, out_err_d, out_last_q, out_last_d;
  logic             run_last;

  assign ra_last = eff_last(rows_a_q);
  assign ca_last = eff_last(cols_a_q);
  assign rb_last = eff_last(rows_b_q);
  assign cb_last = eff_last(cols_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_REG_W'(1);
      cols_a_q <= DIM_REG_W'(1);
      rows_b_q <= DIM_REG_W'(1);
      cols_b_q <= DIM_REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_A: rows_a_q <= cfg_data_i;
        CFG_COLS_A: cols_a_q <= cfg_data_i;
        CFG_ROWS_B: rows_b_q <= cfg_data_i;
        CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // element stores
  assign load_i.ready = (state_q == S_IDLE);
  assign load_hs      = load_i.valid && load_i.ready;
  assign in_range     = (DIM_CMP_W'(load_i.row_index) < MAX_DIM_V) &&
                        (DIM_CMP_W'(load_i.col_index) < MAX_DIM_V);
  assign waddr        = ADDR_W'(load_i.row_index * MAX_DIM + load_i.col_index);
  assign a_raddr      = ADDR_W'(i_q * MAX_DIM + k_q);
  assign b_raddr      = ADDR_W'(k_q * MAX_DIM + j_q);

  always_ff @(posedge clk_i) begin
    if (load_hs && in_range && !load_i.which_matrix) begin
      left_mem[waddr] <= load_i.element;
    end
    a_rd_q <= left_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load_hs && in_range && load_i.which_matrix) begin
      right_mem[waddr] <= load_i.element;
    end
    b_rd_q <= right_mem[b_raddr];
  end

  mm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rd_ctrl_q),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // sequencer
  assign out_free = !out_valid_q || result_o.ready;
  assign run_last = (i_q == ra_last) && (j_q == cb_last);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    rd_ctrl_d   = '0;
    out_load    = 1'b0;
    out_prod_d  = acc;
    out_row_d   = POS_W'(i_q);
    out_col_d   = POS_W'(j_q);
    out_err_d   = 1'b0;
    out_last_d  = run_last;
    case (state_q)
      S_IDLE: begin
        if (load_hs && load_i.last_load) begin
          i_d = '0;
          j_d = '0;
          k_d = '0;
          state_d = (ca_last != rb_last) ? S_ERR : S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_ctrl_d.valid = 1'b1;
        rd_ctrl_d.first = (k_q == '0);
        rd_ctrl_d.last  = (k_q == ca_last);
        if (k_q == ca_last) begin
          k_d     = '0;
          state_d = S_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (mac_done) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (run_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (j_q == cb_last) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      S_ERR: begin
        out_prod_d = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_err_d  = 1'b1;
        out_last_d = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rd_ctrl_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rd_ctrl_q   <= rd_ctrl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_prod_q <= out_prod_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_err_q  <= out_err_d;
      out_last_q <= out_last_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.product     = out_prod_q;
  assign result_o.out_row     = out_row_q;
  assign result_o.out_col     = out_col_q;
  assign result_o.size_error  = out_err_q;
  assign result_o.last_result = out_last_q;

  // checks
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == S_WAIT)
    else $error("accumulator finished outside the wait state");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ISSUE |-> k_q <= ca_last)
    else $error("inner index beyond inner dimension");

  a_push_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |-> !rd_ctrl_q.valid)
    else $error("result handed over with reads still in flight");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_err_d |=> out_valid_q && out_last_q && out_prod_q == '0)
    else $error("error word not marked last or product not zero");

endmodule
